FILE: sv/cbnf_pkg.sv
// ----------------------------------------------------------------------------
// cbnf_pkg
// Shared widths, constants and control types for the counting Bloom n-gram
// filter.
// ----------------------------------------------------------------------------
package cbnf_pkg;

  // Payload widths.
  localparam int TOKEN_W     = 32;
  localparam int NGRAM_LEN_W = 5;
  localparam int THRESH_W    = 8;
  localparam int BUCKET_W    = 20;
  localparam int COUNT_W     = 8;
  localparam int HASH_W      = 64;

  // Default sizes handed to the top level.
  localparam int          MAX_WINDOW_DEF     = 16;
  localparam longint      FILTER_ENTRIES_DEF = 64'd1048576;

  // FNV-1a 64 constants. The prime is 2^40 + 0x1B3, so a step is a shift
  // plus a narrow multiply.
  localparam logic [HASH_W-1:0] FNV_BASIS    = 64'hCBF29CE484222325;
  localparam logic [HASH_W-1:0] FNV_PRIME    = 64'h00000100000001B3;
  localparam int                FNV_SHIFT    = 40;
  localparam logic [8:0]        FNV_PRIME_LO = FNV_PRIME[8:0];

  // Saturation value of a counter.
  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

  // Configuration port.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [0:0] REG_NGRAM_LEN = 1'b0;
  localparam logic [0:0] REG_THRESH    = 1'b1;
  localparam logic [NGRAM_LEN_W-1:0] NGRAM_LEN_RST = 5'd2;
  localparam logic [THRESH_W-1:0]    THRESH_RST    = 8'd2;

  // Control from the sequencer to the hash unit.
  typedef struct packed {
    logic load;  // shift in a token and restart the hash
    logic step;  // fold one window token into the hash
  } hash_ctl_t;

endpackage

FILE: sv/cbnf_req_if.sv
// ----------------------------------------------------------------------------
// cbnf_req_if
// Request channel: one token with its mode and document-start mark.
// ----------------------------------------------------------------------------
interface cbnf_req_if;
  import cbnf_pkg::*;

  logic               valid;
  logic               ready;
  logic               mode;
  logic [TOKEN_W-1:0] token;
  logic               doc_start;

  modport source (output valid, output mode, output token, output doc_start, input ready);
  modport sink   (input valid, input mode, input token, input doc_start, output ready);
endinterface

FILE: sv/cbnf_rsp_if.sv
// ----------------------------------------------------------------------------
// cbnf_rsp_if
// Response channel: window flag, bucket, counter value and pass flag.
// ----------------------------------------------------------------------------
interface cbnf_rsp_if;
  import cbnf_pkg::*;

  logic                valid;
  logic                ready;
  logic                window_valid;
  logic [BUCKET_W-1:0] bucket;
  logic [COUNT_W-1:0]  count;
  logic                passes;

  modport source (output valid, output window_valid, output bucket, output count,
                  output passes, input ready);
  modport sink   (input valid, input window_valid, input bucket, input count,
                  input passes, output ready);
endinterface

FILE: sv/counting_bloom_ngram_filter_core.sv
// Flow: a token that completes no window goes from acceptance to the update
// state; a full window of L tokens passes the hash state, where the single FNV
// step unit folds one token per cycle, then the read and update states. One
// request is in flight; a held response not yet taken stalls the update state.
// Reset: the counter store is cleared by a pass over all FILTER_ENTRIES
// counters, one counter per cycle, during which no request is taken.
// ----------------------------------------------------------------------------
// counting_bloom_ngram_filter_core
// Keeps the last tokens of a document, hashes each full window with FNV-1a 64
// and counts or queries a saturating 8-bit counter in the bucket it selects.
// ----------------------------------------------------------------------------
module counting_bloom_ngram_filter_core #(
  parameter int     MAX_WINDOW     = cbnf_pkg::MAX_WINDOW_DEF,
  parameter longint FILTER_ENTRIES = cbnf_pkg::FILTER_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  cbnf_req_if.sink                        req,
  cbnf_rsp_if.source                      rsp,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cbnf_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [cbnf_pkg::APB_DATA_W-1:0] pwdata,
  output logic [cbnf_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import cbnf_pkg::*;

  localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
  localparam int ADDR_W = $clog2(FILTER_ENTRIES);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_UPDATE
  } state_t;

  state_t state;

  logic [NGRAM_LEN_W-1:0] ngram_len;
  logic [THRESH_W-1:0]    support_threshold;

  logic [ADDR_W-1:0] clr_ptr;
  logic [LEN_W-1:0]  tid;
  logic [LEN_W-1:0]  tid_base;
  logic [LEN_W-1:0]  tid_next;
  logic [LEN_W-1:0]  len_eff;
  logic              win_next;
  logic              win;
  logic              mode_q;
  logic              accept;
  logic              slot_free;

  hash_ctl_t         hash_ctl;
  logic [HASH_W-1:0] hash;
  logic              hash_last;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_wr_addr;
  logic [COUNT_W-1:0] ram_wr_data;
  logic [COUNT_W-1:0] ram_rd_data;
  logic [COUNT_W-1:0] cnt_new;

  logic                rsp_valid;
  logic                rsp_window_valid;
  logic [BUCKET_W-1:0] rsp_bucket;
  logic [COUNT_W-1:0]  rsp_count;
  logic                rsp_passes;

  cbnf_regs u_regs (
    .clk               (clk),
    .rst               (rst),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .ngram_len         (ngram_len),
    .support_threshold (support_threshold)
  );

  cbnf_hasher #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_hasher (
    .clk   (clk),
    .token (req.token),
    .len   (len_eff),
    .ctl   (hash_ctl),
    .hash  (hash),
    .last  (hash_last)
  );

  cbnf_counter_ram #(
    .FILTER_ENTRIES (FILTER_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (state == ST_READ),
    .rd_addr (hash[ADDR_W-1:0]),
    .rd_data (ram_rd_data)
  );

  // Effective window length: zero acts as one, large values clamp.
  always_comb begin
    if (ngram_len == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(ngram_len) > 32'(MAX_WINDOW)) begin
      len_eff = LEN_W'(MAX_WINDOW);
    end else begin
      len_eff = LEN_W'(ngram_len);
    end
  end

  // Document token count after this token, and whether a window is full.
  always_comb begin
    tid_base = req.doc_start ? '0 : tid;
    tid_next = (tid_base < LEN_W'(MAX_WINDOW)) ? tid_base + 1'b1 : tid_base;
    win_next = (tid_next >= len_eff);
  end

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);
  assign slot_free = !rsp_valid || rsp.ready;

  assign hash_ctl.load = accept;
  assign hash_ctl.step = (state == ST_HASH);

  // Counter update: increment in count mode, saturating.
  assign cnt_new = (!mode_q && ram_rd_data != COUNT_MAX) ? ram_rd_data + 1'b1 : ram_rd_data;

  // Store write: zero during the clear pass, else the updated counter.
  always_comb begin
    if (state == ST_CLEAR) begin
      ram_we      = 1'b1;
      ram_wr_addr = clr_ptr;
      ram_wr_data = '0;
    end else begin
      ram_we      = (state == ST_UPDATE) && slot_free && win && !mode_q;
      ram_wr_addr = hash[ADDR_W-1:0];
      ram_wr_data = cnt_new;
    end
  end

  // Sequencer with the response register. A response taken while a new one
  // is loaded is handled by the update arm alone.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_ptr   <= '0;
      tid       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp.ready && state != ST_UPDATE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_ptr <= clr_ptr + 1'b1;
          if (&clr_ptr) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            tid    <= tid_next;
            mode_q <= req.mode;
            win    <= win_next;
            state  <= win_next ? ST_HASH : ST_UPDATE;
          end
        end
        ST_HASH: begin
          if (hash_last) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (slot_free) begin
            rsp_valid        <= 1'b1;
            rsp_window_valid <= win;
            rsp_bucket       <= win ? BUCKET_W'(hash[ADDR_W-1:0]) : '0;
            rsp_count        <= win ? cnt_new : '0;
            rsp_passes       <= win && (cnt_new >= support_threshold);
            state            <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.window_valid = rsp_window_valid;
  assign rsp.bucket       = rsp_bucket;
  assign rsp.count        = rsp_count;
  assign rsp.passes       = rsp_passes;

  // One request in flight: none is taken right after another.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req.ready)
    else $error("request accepted while another is in flight");

  // Outside the clear pass only a counting window writes the store.
  a_write_only_count: assert property (@(posedge clk) disable iff (rst)
    (ram_we && state != ST_CLEAR) |-> (win && !mode_q))
    else $error("counter write outside a counting window");

  // An incremented counter is never written back as zero.
  a_write_nonzero: assert property (@(posedge clk) disable iff (rst)
    (ram_we && state != ST_CLEAR) |-> (ram_wr_data != '0))
    else $error("counter wrapped to zero");

  // A response without a window carries all-zero fields.
  a_empty_rsp: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.window_valid) |-> (rsp.bucket == '0 && rsp.count == '0 && !rsp.passes))
    else $error("response without a window has nonzero fields");

endmodule

FILE: sv/cbnf_regs.sv
// ----------------------------------------------------------------------------
// cbnf_regs
// APB-style configuration registers: n-gram length and support threshold.
// ----------------------------------------------------------------------------
module cbnf_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cbnf_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [cbnf_pkg::APB_DATA_W-1:0] pwdata,
  output logic [cbnf_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  output logic [cbnf_pkg::NGRAM_LEN_W-1:0] ngram_len,
  output logic [cbnf_pkg::THRESH_W-1:0]    support_threshold
);
  import cbnf_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register writes; the register index is the word address.
  always_ff @(posedge clk) begin
    if (rst) begin
      ngram_len         <= NGRAM_LEN_RST;
      support_threshold <= THRESH_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_NGRAM_LEN: ngram_len         <= pwdata[NGRAM_LEN_W-1:0];
        REG_THRESH:    support_threshold <= pwdata[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    unique case (paddr[2])
      REG_NGRAM_LEN: prdata = APB_DATA_W'(ngram_len);
      REG_THRESH:    prdata = APB_DATA_W'(support_threshold);
      default:       prdata = '0;
    endcase
  end

endmodule

FILE: sv/cbnf_hasher.sv
// ----------------------------------------------------------------------------
// cbnf_hasher
// Token window shift line and an iterative FNV-1a 64 unit that folds one
// window token per cycle, oldest first.
// ----------------------------------------------------------------------------
module cbnf_hasher #(
  parameter int MAX_WINDOW = cbnf_pkg::MAX_WINDOW_DEF,
  localparam int LEN_W = $clog2(MAX_WINDOW + 1),
  localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
  input  logic                         clk,
  input  logic [cbnf_pkg::TOKEN_W-1:0] token,
  input  logic [LEN_W-1:0]             len,
  input  cbnf_pkg::hash_ctl_t          ctl,
  output logic [cbnf_pkg::HASH_W-1:0]  hash,
  output logic                         last
);
  import cbnf_pkg::*;

  logic [TOKEN_W-1:0] window [MAX_WINDOW];
  logic [IDX_W-1:0]   ptr;
  logic [HASH_W-1:0]  mixed;
  logic [HASH_W-1:0]  hash_next;

  // One FNV step: xor the token, then multiply by the prime as shift plus
  // a 9-bit constant multiply.
  always_comb begin
    mixed     = hash ^ HASH_W'(window[ptr]);
    hash_next = (mixed << FNV_SHIFT) + (mixed * HASH_W'(FNV_PRIME_LO));
  end

  assign last = (ptr == IDX_W'(MAX_WINDOW - 1));

  // Window shift on a new token; the newest token sits at the top entry.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      for (int i = 0; i < MAX_WINDOW - 1; i++) begin
        window[i] <= window[i + 1];
      end
      window[MAX_WINDOW - 1] <= token;
    end
  end

  // Hash register and window pointer.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      hash <= FNV_BASIS;
      ptr  <= IDX_W'(MAX_WINDOW - int'(len));
    end else if (ctl.step) begin
      hash <= hash_next;
      ptr  <= ptr + 1'b1;
    end
  end

endmodule

FILE: sv/cbnf_counter_ram.sv
// ----------------------------------------------------------------------------
// cbnf_counter_ram
// Counter store: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module cbnf_counter_ram #(
  parameter longint FILTER_ENTRIES = cbnf_pkg::FILTER_ENTRIES_DEF,
  localparam int ADDR_W = $clog2(FILTER_ENTRIES)
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [ADDR_W-1:0]            wr_addr,
  input  logic [cbnf_pkg::COUNT_W-1:0] wr_data,
  input  logic                         rd_en,
  input  logic [ADDR_W-1:0]            rd_addr,
  output logic [cbnf_pkg::COUNT_W-1:0] rd_data
);
  import cbnf_pkg::*;

  logic [COUNT_W-1:0] mem [FILTER_ENTRIES];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: tb/sv/counting_bloom_ngram_filter_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counting_bloom_ngram_filter_core_test
// Drives token requests through the n-gram counting filter and predicts every
// response with an independent FNV-1a 64 window hash and a sparse copy of the
// counter store. Covers the register settings, document boundaries, counter
// saturation, random idling on both channels and a long response hold-off.
// ----------------------------------------------------------------------------
module counting_bloom_ngram_filter_core_test;
  import cbnf_pkg::*;

  // Request modes.
  localparam logic MODE_COUNT = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Hash constants and sizes as the filter defines them.
  localparam logic [63:0] HASH_SEED  = 64'd14695981039346656037;
  localparam logic [63:0] HASH_MULT  = 64'd1099511628211;
  localparam int          WIN_DEPTH  = 16;
  localparam logic [7:0]  SAT_COUNT  = 8'd255;
  localparam int          CYCLE_LIMIT = 4_000_000;
  localparam int          VOCAB_SIZE  = 6;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_profile_t;

  typedef struct packed {
    logic                window_valid;
    logic [BUCKET_W-1:0] bucket;
    logic [COUNT_W-1:0]  count;
    logic                passes;
  } answer_t;

  // Tracks the filter state and the responses still owed by the block.
  class bloom_tracker;
    bit [4:0]   ngram_len;
    bit [7:0]   threshold;
    bit [31:0]  window [WIN_DEPTH];
    int         tokens_in_doc;
    bit [7:0]   counters [bit [19:0]];
    answer_t    owed_answers [$];
    int         failures;
    int         answers;

    function new();
      ngram_len = 5'd2;
      threshold = 8'd2;
      foreach (window[i]) window[i] = '0;
      tokens_in_doc = 0;
      failures = 0;
      answers = 0;
    endfunction

    function void write_reg(logic [0:0] index, logic [31:0] value);
      if (index == REG_NGRAM_LEN) ngram_len = value[4:0];
      else if (index == REG_THRESH) threshold = value[7:0];
    endfunction

    // Work out the response to one accepted request.
    function void take_token(logic mode, logic [31:0] tok, logic doc_start);
      int        span;
      bit [63:0] h;
      bit [19:0] idx;
      bit [7:0]  cnt;
      answer_t   a;
      if (doc_start) tokens_in_doc = 0;
      for (int i = 0; i < WIN_DEPTH - 1; i++) window[i] = window[i + 1];
      window[WIN_DEPTH - 1] = tok;
      if (tokens_in_doc < WIN_DEPTH) tokens_in_doc++;
      span = (ngram_len == 0) ? 1 : ((ngram_len > WIN_DEPTH) ? WIN_DEPTH : ngram_len);
      if (tokens_in_doc < span) begin
        a = '0;
        owed_answers.insert(owed_answers.size(), a);
        return;
      end
      // Fold the window oldest first.
      h = HASH_SEED;
      for (int i = WIN_DEPTH - span; i < WIN_DEPTH; i++) begin
        h = h ^ {32'd0, window[i]};
        h = h * HASH_MULT;
      end
      idx = h[19:0];
      cnt = counters.exists(idx) ? counters[idx] : 8'd0;
      if (mode == MODE_COUNT && cnt != SAT_COUNT) begin
        cnt = cnt + 8'd1;
        counters[idx] = cnt;
      end
      a.window_valid = 1'b1;
      a.bucket = idx;
      a.count = cnt;
      a.passes = (cnt >= threshold);
      owed_answers.insert(owed_answers.size(), a);
    endfunction

    function void flag_error(string msg);
      failures++;
      if (failures <= 10) $display("ERROR: %s", msg);
    endfunction

    // Compare one accepted response with the oldest owed one.
    function void compare_answer(logic wv, logic [BUCKET_W-1:0] bucket,
                                 logic [COUNT_W-1:0] count, logic passes);
      answer_t want;
      answers++;
      if (owed_answers.size() == 0) begin
        flag_error($sformatf("response %0d unexpected: wv=%0d bucket=%05h count=%0d passes=%0d",
                             answers, wv, bucket, count, passes));
        return;
      end
      want = owed_answers.pop_front();
      if (wv !== want.window_valid || bucket !== want.bucket ||
          count !== want.count || passes !== want.passes)
        flag_error($sformatf({"response %0d: expected wv=%0d bucket=%05h count=%0d ",
                              "passes=%0d, got wv=%0d bucket=%05h count=%0d passes=%0d"},
                             answers, want.window_valid, want.bucket, want.count,
                             want.passes, wv, bucket, count, passes));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  cbnf_req_if req_ch ();
  cbnf_rsp_if rsp_ch ();

  bloom_tracker board = new();
  int  send_idle_pct = 0;
  int  rsp_stall_pct = 0;
  bit  hold_rsp = 1'b0;
  int  cycle_count = 0;
  bit [31:0] vocab [VOCAB_SIZE];

  counting_bloom_ngram_filter_core dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk = ~clk;

  // Run limit; it also has to cover the reset clearing pass.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Response side: random stalls, forced low during a hold-off.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_ch.ready = !rst && !hold_rsp && ($urandom_range(0, 99) >= rsp_stall_pct);
    end
  end

  // Check every accepted response.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
      board.compare_answer(rsp_ch.window_valid, rsp_ch.bucket, rsp_ch.count, rsp_ch.passes);
  end

  // Offer one request and wait for it to be taken. Starts and ends at a falling edge.
  task automatic push_token(logic mode, logic [31:0] tok, logic doc_start);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.mode = mode;
    req_ch.token = tok;
    req_ch.doc_start = doc_start;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    board.take_token(mode, tok, doc_start);
    @(negedge clk);
  endtask

  // Stop requesting and wait until every owed response has come back.
  task automatic settle();
    req_ch.valid = 1'b0;
    while (board.owed_answers.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Register write: setup cycle, then access cycle.
  task automatic apb_write(logic [0:0] index, logic [31:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {index, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    board.write_reg(index, value);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Upper data bits are random; only the register width is kept.
  task automatic configure(int len, int thr);
    apb_write(REG_NGRAM_LEN, ($urandom() & 32'hFFFF_FFE0) | (len & 32'h1F));
    apb_write(REG_THRESH, ($urandom() & 32'hFFFF_FF00) | (thr & 32'hFF));
  endtask

  task automatic set_idling(idle_profile_t p);
    case (p)
      IDLE_NONE: begin
        send_idle_pct = 0;
        rsp_stall_pct = 0;
      end
      IDLE_SEND: begin
        send_idle_pct = 88;
        rsp_stall_pct = 0;
      end
      IDLE_RECV: begin
        send_idle_pct = 0;
        rsp_stall_pct = 88;
      end
      default: begin
        send_idle_pct = 26;
        rsp_stall_pct = 26;
      end
    endcase
  endtask

  // Long response hold-off so the block backs up and stalls its input.
  task automatic hold_answers(int cycles);
    @(posedge clk);
    hold_rsp = 1'b1;
    repeat (cycles) @(posedge clk);
    hold_rsp = 1'b0;
  endtask

  // Mostly a small vocabulary so windows repeat and counters climb.
  function automatic logic [31:0] pick_token();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return vocab[$urandom_range(0, VOCAB_SIZE - 1)];
    if (r < 75) return 32'h0000_0000;
    if (r < 80) return 32'hFFFF_FFFF;
    return $urandom();
  endfunction

  // Documents of random length, with an occasional stray document start.
  task automatic run_documents(int n_items, int max_doc);
    int   doc_left;
    logic start;
    logic mode;
    doc_left = 0;
    repeat (n_items) begin
      if (doc_left == 0) begin
        doc_left = $urandom_range(1, max_doc);
        start = 1'b1;
      end else begin
        start = ($urandom_range(0, 19) == 0);
      end
      mode = ($urandom_range(0, 99) < 25) ? MODE_QUERY : MODE_COUNT;
      push_token(mode, pick_token(), start);
      doc_left--;
    end
  endtask

  initial begin
    static int            phase_len  [10] = '{2, 1, 3, 16, 31, 0, 2, 5, 17, 1};
    static int            phase_thr  [10] = '{1, 2, 0, 3, 1, 4, 255, 2, 1, 3};
    static int            phase_cnt  [10] = '{110, 100, 100, 100, 80, 100, 100, 100, 80, 120};
    static int            phase_hold [10] = '{400, 0, 0, 0, 0, 0, 0, 0, 0, 300};
    static idle_profile_t phase_idle [10] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
                                              IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
                                              IDLE_RECV, IDLE_NONE};
    int            span;
    logic [31:0]   sat_tok;

    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.mode = MODE_COUNT;
    req_ch.token = '0;
    req_ch.doc_start = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    foreach (vocab[i]) vocab[i] = $urandom();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed requests at the reset settings (two-token windows, threshold two).
    set_idling(IDLE_NONE);
    push_token(MODE_COUNT, 32'h0000_0000, 1'b0);  // first token, window not yet full
    push_token(MODE_COUNT, 32'hFFFF_FFFF, 1'b0);  // first window, below threshold
    push_token(MODE_COUNT, 32'h0000_0000, 1'b1);  // new document empties the window
    push_token(MODE_COUNT, 32'hFFFF_FFFF, 1'b0);  // same window again, now passes
    push_token(MODE_QUERY, 32'h0000_0000, 1'b1);
    push_token(MODE_QUERY, 32'hFFFF_FFFF, 1'b0);  // query reads without counting
    push_token(MODE_COUNT, 32'hFFFF_FFFF, 1'b0);
    push_token(MODE_QUERY, 32'hFFFF_FFFF, 1'b1);
    settle();

    // Zero length acts as one; zero threshold passes everything.
    configure(0, 0);
    push_token(MODE_QUERY, 32'hA5A5_5A5A, 1'b0);
    push_token(MODE_COUNT, 32'hA5A5_5A5A, 1'b1);
    push_token(MODE_COUNT, 32'h8000_0001, 1'b0);
    settle();

    // Length grows in the middle of a document.
    configure(3, 255);
    push_token(MODE_COUNT, 32'h0000_0001, 1'b0);
    push_token(MODE_QUERY, 32'h7FFF_FFFE, 1'b0);
    settle();

    // Drive one bucket past saturation with single-token windows.
    configure(1, 255);
    set_idling(IDLE_RECV);
    sat_tok = $urandom();
    repeat (262) push_token(MODE_COUNT, sat_tok, ($urandom_range(0, 7) == 0));
    repeat (3) push_token(MODE_QUERY, sat_tok, 1'b0);
    settle();

    // Random phases over the register settings and idling profiles.
    for (int p = 0; p < 10; p++) begin
      configure(phase_len[p], phase_thr[p]);
      set_idling(phase_idle[p]);
      span = (phase_len[p] == 0) ? 1 : ((phase_len[p] > WIN_DEPTH) ? WIN_DEPTH : phase_len[p]);
      if (phase_hold[p] > 0) begin
        fork
          hold_answers(phase_hold[p]);
          run_documents(phase_cnt[p], 2 * span + 3);
        join
      end else begin
        run_documents(phase_cnt[p], 2 * span + 3);
      end
      settle();
    end

    // Let any stray response show up before deciding.
    set_idling(IDLE_NONE);
    repeat (25) @(negedge clk);
    if (board.failures == 0 && board.owed_answers.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
